FILE: rtl/core/cycloid_swing_trajectory_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the swing trajectory core
// Both expect signals named clock and reset in the calling scope.
// ----------------------------------------------------------------------------
`ifndef CYCLOID_SWING_TRAJECTORY_CORE_ASSERT_SVH
`define CYCLOID_SWING_TRAJECTORY_CORE_ASSERT_SVH

// Same-cycle implication
`define CST_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared widths, constants, types and rounding helpers of the swing core.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int PosW   = 24;
   localparam int VelW   = 32;
   localparam int PhaseW = 16;
   localparam int HeightW = 18;
   localparam int InvTW  = 16;
   localparam int MulAW  = 36;
   localparam int MulBW  = 26;
   localparam int ProdW  = MulAW + MulBW;
   localparam int AccW   = 64;
   localparam int SinW   = 17;

   // 1/pi in Q28 and pi in Q13
   localparam int unsigned InvPiQ28 = 85445659;
   localparam int unsigned PiQ13    = 25736;

   typedef logic signed [MulAW-1:0] mul_a_type;
   typedef logic signed [MulBW-1:0] mul_b_type;
   typedef logic signed [ProdW-1:0] prod_type;
   typedef logic signed [AccW-1:0]  acc_type;
   typedef logic signed [PosW-1:0]  pos_type;
   typedef logic signed [VelW-1:0]  vel_type;
   typedef logic signed [SinW-1:0]  sin_type;

   // operand pair for the shared multiplier
   typedef struct packed {
      mul_a_type a;
      mul_b_type b;
   } mul_op_type;

   // round half up by n bits (floor of v/2^n + 1/2)
   function automatic acc_type rnd_shift(acc_type v, int unsigned n);
      acc_type half;
      half = acc_type'(1) <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   function automatic pos_type sat_pos(acc_type v);
      acc_type hi;
      acc_type lo;
      hi = (acc_type'(1) <<< (PosW - 1)) - acc_type'(1);
      lo = -hi - acc_type'(1);
      if (v > hi) begin
         return pos_type'(hi);
      end else if (v < lo) begin
         return pos_type'(lo);
      end
      return pos_type'(v);
   endfunction

   function automatic vel_type sat_vel(acc_type v);
      acc_type hi;
      acc_type lo;
      hi = (acc_type'(1) <<< (VelW - 1)) - acc_type'(1);
      lo = -hi - acc_type'(1);
      if (v > hi) begin
         return vel_type'(hi);
      end else if (v < lo) begin
         return vel_type'(lo);
      end
      return vel_type'(v);
   endfunction

endpackage

FILE: rtl/core/cst_channels.sv
// ----------------------------------------------------------------------------
// cst channels
// Valid/ready request and response channels of the swing trajectory core.
// ----------------------------------------------------------------------------
interface cst_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  leg;
   logic                        contact;
   logic [cst_pkg::PhaseW-1:0]  phase;
   logic signed [cst_pkg::PosW-1:0] meas_x;
   logic signed [cst_pkg::PosW-1:0] meas_y;
   logic signed [cst_pkg::PosW-1:0] meas_z;
   logic signed [cst_pkg::PosW-1:0] target_x;
   logic signed [cst_pkg::PosW-1:0] target_y;
   logic signed [cst_pkg::PosW-1:0] target_z;
   logic                        restart;

   modport source (output valid, leg, contact, phase, meas_x, meas_y, meas_z,
                   target_x, target_y, target_z, restart, input ready);
   modport sink (input valid, leg, contact, phase, meas_x, meas_y, meas_z,
                 target_x, target_y, target_z, restart, output ready);
endinterface

interface cst_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  out_leg;
   logic signed [cst_pkg::PosW-1:0] pos_x;
   logic signed [cst_pkg::PosW-1:0] pos_y;
   logic signed [cst_pkg::PosW-1:0] pos_z;
   logic signed [cst_pkg::VelW-1:0] vel_x;
   logic signed [cst_pkg::VelW-1:0] vel_y;
   logic signed [cst_pkg::VelW-1:0] vel_z;

   modport source (output valid, out_leg, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   input ready);
   modport sink (input valid, out_leg, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 output ready);
endinterface

FILE: rtl/core/cst_sine_rom.sv
// ----------------------------------------------------------------------------
// cst_sine_rom
// Quarter-wave sine table, Q15, with quadrant folding and registered output.
// ----------------------------------------------------------------------------
module cst_sine_rom #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                        clock,
   input  logic [cst_pkg::PhaseW-1:0]  phase,
   output cst_pkg::sin_type            value_ff
);

   localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int ScW  = 14 + IdxW;
   localparam longint unsigned HalfPiQ30 = 64'd1686629713;
   localparam longint unsigned TaylorDiv [0:7] = '{6, 20, 42, 72, 110, 156, 210, 272};

   // Taylor series to x^17 in Q30, rounded to Q15; elaboration only
   function automatic logic [15:0] sine_entry(int unsigned k);
      longint unsigned x;
      longint unsigned t;
      longint          sum;
      x = (longint'(k) * HalfPiQ30) / SINE_TABLE_DEPTH;
      t = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = t / TaylorDiv[n-1];
         if (n[0]) begin
            sum = sum - longint'(t);
         end else begin
            sum = sum + longint'(t);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 16384) >>> 15;
      if (sum > 32768) begin
         sum = 32768;
      end
      return sum[15:0];
   endfunction

   logic [15:0] sine_tbl [0:SINE_TABLE_DEPTH];

   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tbl
      localparam logic [15:0] Entry = sine_entry(k);
      assign sine_tbl[k] = Entry;
   end

   // table index from the in-quadrant angle
   logic [1:0]      quad;
   logic [ScW-1:0]  scaled;
   logic [IdxW-1:0] idx;
   logic [IdxW-1:0] addr;
   cst_pkg::sin_type mag;

   always_comb begin
      quad   = phase[15:14];
      scaled = ScW'(phase[13:0]) * ScW'(SINE_TABLE_DEPTH);
      idx    = IdxW'(scaled >> 14);
      addr   = quad[0] ? (IdxW'(SINE_TABLE_DEPTH) - idx) : idx;
      mag    = cst_pkg::sin_type'(sine_tbl[addr]);
   end

   always_ff @(posedge clock) begin
      value_ff <= quad[1] ? -mag : mag;
   end

endmodule

FILE: rtl/core/cst_mul.sv
// ----------------------------------------------------------------------------
// cst_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cst_mul (
   input  logic                  clock,
   input  cst_pkg::mul_op_type   op,
   output cst_pkg::prod_type     prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= cst_pkg::prod_type'(op.a) * cst_pkg::prod_type'(op.b);
   end

endmodule

FILE: rtl/core/cst_seq.sv
// ----------------------------------------------------------------------------
// cst_seq
// Sequencer: start point store, stance handling and the step program that
// drives the shared multiplier for one swing request.
// ----------------------------------------------------------------------------
`include "cycloid_swing_trajectory_core_assert.svh"

module cst_seq #(
   parameter int LEG_COUNT = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   cst_req_if.sink                       req,
   cst_rsp_if.source                     rsp,
   input  logic [cst_pkg::HeightW-1:0]   swing_height,
   input  logic [cst_pkg::InvTW-1:0]     inv_swing_time,
   output logic [cst_pkg::PhaseW-1:0]    rom_phase,
   input  cst_pkg::sin_type              rom_value,
   output cst_pkg::mul_op_type           mul_op,
   input  cst_pkg::prod_type             prod
);

   localparam int LegW = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
   localparam int DiffW = cst_pkg::PosW + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   // step program
   localparam logic [3:0] StepPhaseSq = 4'd0;
   localparam logic [3:0] StepSinK    = 4'd1;
   localparam logic [3:0] StepSinPi   = 4'd2;
   localparam logic [3:0] StepGx      = 4'd3;
   localparam logic [3:0] StepGy      = 4'd4;
   localparam logic [3:0] StepCx      = 4'd5;
   localparam logic [3:0] StepCy      = 4'd6;
   localparam logic [3:0] StepWx      = 4'd7;
   localparam logic [3:0] StepWy      = 4'd8;
   localparam logic [3:0] StepHc      = 4'd9;
   localparam logic [3:0] StepPqz     = 4'd10;
   localparam logic [3:0] StepHs      = 4'd11;
   localparam logic [3:0] StepPz      = 4'd12;
   localparam logic [3:0] StepBubble  = 4'd13;
   localparam logic [3:0] StepWz      = 4'd14;
   localparam logic [3:0] StepLast    = 4'd15;

   state_type              state_ff;
   logic [3:0]             step_ff;
   logic                   rsp_valid_ff;
   logic [LEG_COUNT-1:0]   needs_latch_ff;

   // start point store, one entry per leg
   cst_pkg::pos_type st_x_mem [LEG_COUNT];
   cst_pkg::pos_type st_y_mem [LEG_COUNT];
   cst_pkg::pos_type st_z_mem [LEG_COUNT];

   // per-request working registers
   logic [1:0]                  leg_ff;
   logic [cst_pkg::PhaseW-1:0]  p_ff;
   cst_pkg::pos_type            st_x_ff, st_y_ff, st_z_ff, tz_ff;
   logic signed [DiffW-1:0]     dx_ff, dy_ff;
   cst_pkg::sin_type            s_ff;
   logic signed [17:0]          cm_ff;
   logic [29:0]                 pq_ff;
   logic signed [30:0]          g_ff;
   logic signed [31:0]          t1_ff;
   cst_pkg::mul_a_type          vx1_ff, vy1_ff, n1_ff;
   cst_pkg::acc_type            zacc_ff, nacc_ff;
   cst_pkg::pos_type            res_px_ff, res_py_ff, res_pz_ff;
   cst_pkg::vel_type            res_vx_ff, res_vy_ff, res_vz_ff;

   // response register
   logic [1:0]                  rsp_leg_ff;
   cst_pkg::pos_type            rsp_px_ff, rsp_py_ff, rsp_pz_ff;
   cst_pkg::vel_type            rsp_vx_ff, rsp_vy_ff, rsp_vz_ff;

   logic                   accept;
   logic                   in_range;
   logic [LegW-1:0]        leg_idx;
   logic                   take_meas;
   logic                   out_free;
   cst_pkg::pos_type       new_x, new_y, new_z;
   cst_pkg::acc_type       prod_w;

   // accept decode and start point selection
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      accept    = req.valid && req.ready;
      in_range  = (int'(req.leg) < LEG_COUNT);
      leg_idx   = LegW'(req.leg);
      take_meas = req.restart || needs_latch_ff[leg_idx] ||
                  (req.contact && !req.phase[15]);
      new_x     = take_meas ? req.meas_x : st_x_mem[leg_idx];
      new_y     = take_meas ? req.meas_y : st_y_mem[leg_idx];
      new_z     = take_meas ? req.meas_z : st_z_mem[leg_idx];
      out_free  = !rsp_valid_ff || rsp.ready;
      prod_w    = cst_pkg::acc_type'(prod);
      rom_phase = (state_ff == ST_IDLE) ? req.phase : (p_ff + 16'd16384);
   end

   // multiplier operand program
   always_comb begin
      mul_op.a = '0;
      mul_op.b = '0;
      case (step_ff)
         StepPhaseSq: begin
            mul_op.a = cst_pkg::mul_a_type'(p_ff);
            mul_op.b = cst_pkg::mul_b_type'(p_ff);
         end
         StepSinK: begin
            mul_op.a = cst_pkg::mul_a_type'(cst_pkg::InvPiQ28);
            mul_op.b = cst_pkg::mul_b_type'(s_ff);
         end
         StepSinPi: begin
            mul_op.a = cst_pkg::mul_a_type'(s_ff);
            mul_op.b = cst_pkg::mul_b_type'(cst_pkg::PiQ13);
         end
         StepGx: begin
            mul_op.a = cst_pkg::mul_a_type'(g_ff);
            mul_op.b = cst_pkg::mul_b_type'(dx_ff);
         end
         StepGy: begin
            mul_op.a = cst_pkg::mul_a_type'(g_ff);
            mul_op.b = cst_pkg::mul_b_type'(dy_ff);
         end
         StepCx: begin
            mul_op.a = cst_pkg::mul_a_type'(cm_ff);
            mul_op.b = cst_pkg::mul_b_type'(dx_ff);
         end
         StepCy: begin
            mul_op.a = cst_pkg::mul_a_type'(cm_ff);
            mul_op.b = cst_pkg::mul_b_type'(dy_ff);
         end
         StepWx: begin
            mul_op.a = vx1_ff;
            mul_op.b = cst_pkg::mul_b_type'(inv_swing_time);
         end
         StepWy: begin
            mul_op.a = vy1_ff;
            mul_op.b = cst_pkg::mul_b_type'(inv_swing_time);
         end
         StepHc: begin
            mul_op.a = cst_pkg::mul_a_type'(cm_ff);
            mul_op.b = cst_pkg::mul_b_type'(swing_height);
         end
         StepPqz: begin
            mul_op.a = cst_pkg::mul_a_type'(pq_ff);
            mul_op.b = cst_pkg::mul_b_type'(tz_ff);
         end
         StepHs: begin
            mul_op.a = cst_pkg::mul_a_type'(t1_ff);
            mul_op.b = cst_pkg::mul_b_type'(swing_height);
         end
         StepPz: begin
            mul_op.a = cst_pkg::mul_a_type'(p_ff);
            mul_op.b = cst_pkg::mul_b_type'(tz_ff);
         end
         StepWz: begin
            mul_op.a = n1_ff;
            mul_op.b = cst_pkg::mul_b_type'(inv_swing_time);
         end
         default: begin
            mul_op.a = '0;
            mul_op.b = '0;
         end
      endcase
   end

   // control state machine and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         needs_latch_ff <= '1;
      end else begin
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // restart marks every leg, except the one latched right now
                  if (req.restart) begin
                     needs_latch_ff <= in_range ? ~(LEG_COUNT'(1) << leg_idx) : '1;
                  end else if (in_range) begin
                     needs_latch_ff[leg_idx] <= 1'b0;
                  end
                  step_ff  <= '0;
                  state_ff <= (in_range && !req.contact) ? ST_RUN : ST_DONE;
               end
            end
            ST_RUN: begin
               if (step_ff == StepLast) begin
                  step_ff  <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // datapath: store, working values and results
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         leg_ff    <= req.leg;
         p_ff      <= req.phase;
         st_x_ff   <= new_x;
         st_y_ff   <= new_y;
         st_z_ff   <= new_z;
         tz_ff     <= req.target_z;
         dx_ff     <= DiffW'(req.target_x) - DiffW'(new_x);
         dy_ff     <= DiffW'(req.target_y) - DiffW'(new_y);
         res_vx_ff <= '0;
         res_vy_ff <= '0;
         res_vz_ff <= '0;
         if (in_range) begin
            st_x_mem[leg_idx] <= new_x;
            st_y_mem[leg_idx] <= new_y;
            st_z_mem[leg_idx] <= new_z;
            res_px_ff <= new_x;
            res_py_ff <= new_y;
            res_pz_ff <= new_z;
         end else begin
            res_px_ff <= '0;
            res_py_ff <= '0;
            res_pz_ff <= '0;
         end
      end
      if (state_ff == ST_RUN) begin
         case (step_ff)
            StepPhaseSq: s_ff <= rom_value;
            StepSinK: begin
               cm_ff <= 18'sd32768 - 18'(rom_value);
               pq_ff <= prod_w[31:2];
            end
            StepSinPi: g_ff <= 31'((cst_pkg::acc_type'(p_ff) <<< 12) -
                                   cst_pkg::rnd_shift(prod_w, 16));
            StepGx: t1_ff <= prod_w[31:0];
            StepGy: res_px_ff <= cst_pkg::sat_pos(cst_pkg::acc_type'(st_x_ff) +
                                                  cst_pkg::rnd_shift(prod_w, 28));
            StepCx: res_py_ff <= cst_pkg::sat_pos(cst_pkg::acc_type'(st_y_ff) +
                                                  cst_pkg::rnd_shift(prod_w, 28));
            StepCy: vx1_ff <= cst_pkg::mul_a_type'(cst_pkg::rnd_shift(prod_w, 7));
            StepWx: vy1_ff <= cst_pkg::mul_a_type'(cst_pkg::rnd_shift(prod_w, 7));
            StepWy: res_vx_ff <= cst_pkg::sat_vel(cst_pkg::rnd_shift(prod_w, 16));
            StepHc: res_vy_ff <= cst_pkg::sat_vel(cst_pkg::rnd_shift(prod_w, 16));
            StepPqz: zacc_ff <= prod_w <<< 14;
            StepHs: res_pz_ff <= cst_pkg::sat_pos(cst_pkg::acc_type'(st_z_ff) +
                                 cst_pkg::rnd_shift(zacc_ff + prod_w, 30));
            StepPz: nacc_ff <= prod_w;
            StepBubble: n1_ff <= cst_pkg::mul_a_type'(
                                 cst_pkg::rnd_shift(nacc_ff + (prod_w <<< 13), 20));
            StepLast: res_vz_ff <= cst_pkg::sat_vel(cst_pkg::rnd_shift(prod_w, 16));
            default: begin
            end
         endcase
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_leg_ff <= leg_ff;
         rsp_px_ff  <= res_px_ff;
         rsp_py_ff  <= res_py_ff;
         rsp_pz_ff  <= res_pz_ff;
         rsp_vx_ff  <= res_vx_ff;
         rsp_vy_ff  <= res_vy_ff;
         rsp_vz_ff  <= res_vz_ff;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.out_leg = rsp_leg_ff;
   assign rsp.pos_x   = rsp_px_ff;
   assign rsp.pos_y   = rsp_py_ff;
   assign rsp.pos_z   = rsp_pz_ff;
   assign rsp.vel_x   = rsp_vx_ff;
   assign rsp.vel_y   = rsp_vy_ff;
   assign rsp.vel_z   = rsp_vz_ff;

   // checks
   `CST_ASSERT_NEXT(a_run_ends_done, state_ff == ST_RUN && step_ff == StepLast, state_ff == ST_DONE, "swing program did not finish")
   `CST_ASSERT_NOW(a_step_idle_zero, state_ff != ST_RUN, step_ff == '0, "step counter left running")
   `CST_ASSERT_NEXT(a_latch_cleared, accept && in_range, !needs_latch_ff[$past(leg_idx)], "start latch flag not cleared")
   `CST_ASSERT_NEXT(a_done_hands_off, state_ff == ST_DONE && out_free, rsp_valid_ff && state_ff == ST_IDLE, "response not issued")

endmodule

FILE: rtl/core/cycloid_swing_trajectory_core.sv
// ----------------------------------------------------------------------------
// cycloid_swing_trajectory_core
// Cycloid foot swing trajectory generator with APB register access.
// ----------------------------------------------------------------------------
// One request is one control tick for one leg; one response comes back for
// each request, in order, on the rsp channel (valid/ready).
// Stance requests and legs beyond the leg count answer without arithmetic:
// the request goes straight from the idle state to the done state.
// Swing requests run a 16-step program on one shared 36x26 multiplier
// and enter the done state when the program ends.
// A new request is taken once the previous one has moved into the response
// register, so the core never works on two requests at once.
// If the receiver stalls, the response register holds; a finished result
// waits in the working registers and the core then takes no new request.
// The APB port holds swing_height at 0x0 and inv_swing_time at 0x4; write
// them only while the core is idle. pready is always high.
// Reset (synchronous, active high) restores the register defaults and marks
// every leg to latch its start point from its first measured position.
// ----------------------------------------------------------------------------
module cycloid_swing_trajectory_core #(
   parameter int LEG_COUNT        = 4,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   cst_req_if.sink      req_ch,
   cst_rsp_if.source    rsp_ch,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam logic RegSwingHeight = 1'b0;
   localparam logic RegInvSwingTime = 1'b1;

   logic [cst_pkg::HeightW-1:0] swing_height_ff;
   logic [cst_pkg::InvTW-1:0]   inv_swing_time_ff;
   logic                        csr_write;
   logic [cst_pkg::PhaseW-1:0]  rom_phase;
   cst_pkg::sin_type            rom_value;
   cst_pkg::mul_op_type         mul_op;
   cst_pkg::prod_type           prod;

   // register file
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         swing_height_ff   <= 18'd80000;
         inv_swing_time_ff <= 16'd1280;
      end else if (csr_write) begin
         case (paddr[2])
            RegSwingHeight:  swing_height_ff   <= pwdata[cst_pkg::HeightW-1:0];
            RegInvSwingTime: inv_swing_time_ff <= pwdata[cst_pkg::InvTW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         RegSwingHeight:  prdata = 32'(swing_height_ff);
         RegInvSwingTime: prdata = 32'(inv_swing_time_ff);
         default:         prdata = '0;
      endcase
   end

   cst_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_rom (
      .clock    (clock),
      .phase    (rom_phase),
      .value_ff (rom_value)
   );

   cst_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (prod)
   );

   cst_seq #(
      .LEG_COUNT (LEG_COUNT)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .swing_height   (swing_height_ff),
      .inv_swing_time (inv_swing_time_ff),
      .rom_phase      (rom_phase),
      .rom_value      (rom_value),
      .mul_op         (mul_op),
      .prod           (prod)
   );

endmodule

FILE: tb/cycloid_swing_trajectory_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycloid_swing_trajectory_core_tb
// Self-checking bench for the cycloid swing trajectory core. Requests drive
// stance and swing ticks for every leg, both ends and bursts of random gait
// cycles, under random gaps and response stalls. A built-in trajectory
// predictor computes each response, which is checked field by field in order.
// ----------------------------------------------------------------------------
module cycloid_swing_trajectory_core_tb;

   localparam int NumLegs    = 4;
   localparam int TableDepth = 256;
   localparam int IdleLimit  = 4000;
   localparam int DrainWait  = 40;

   // register byte addresses
   localparam logic [2:0] AddrSwingHeight = 3'h0;
   localparam logic [2:0] AddrInvSwingTime = 3'h4;

   typedef struct {
      logic [1:0] leg;
      logic       contact;
      logic [15:0] phase;
      cst_pkg::pos_type meas[3];
      cst_pkg::pos_type target[3];
      logic       restart;
   } tick_type;

   typedef struct {
      logic [1:0] leg;
      cst_pkg::pos_type pos[3];
      cst_pkg::vel_type vel[3];
   } motion_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   cst_req_if req_ch ();
   cst_rsp_if rsp_ch ();

   cycloid_swing_trajectory_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   longint  sine_q15[TableDepth+1];
   longint  start_pt[NumLegs][3];
   bit      relatch[NumLegs];
   longint  lift_height;
   longint  inv_swing;
   motion_type pending_motion[$];

   int error_count;
   int request_count;
   int response_count;
   int swing_count;
   int idle_cycles;
   bit no_idle;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // quarter-wave sine table, Taylor series in Q30 rounded to Q15
   function automatic void build_sine_table();
      longint unsigned x;
      longint unsigned t;
      longint sum;
      for (int k = 0; k <= TableDepth; k++) begin
         x = (longint'(k) * 64'd1686629713) / TableDepth;
         t = x;
         sum = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / (longint'(2 * n) * longint'(2 * n + 1));
            if (n % 2 == 1) sum = sum - longint'(t);
            else sum = sum + longint'(t);
         end
         if (sum < 0) sum = 0;
         sum = (sum + 16384) >>> 15;
         sine_q15[k] = (sum > 32768) ? 32768 : sum;
      end
   endfunction

   function automatic longint sine_of(logic [15:0] ph);
      int idx;
      longint v;
      idx = (int'(ph[13:0]) * TableDepth) >> 14;
      v = ph[14] ? sine_q15[TableDepth - idx] : sine_q15[idx];
      return ph[15] ? -v : v;
   endfunction

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic cst_pkg::pos_type clip_pos(longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return cst_pkg::pos_type'(v);
   endfunction

   function automatic cst_pkg::vel_type clip_vel(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return cst_pkg::vel_type'(v);
   endfunction

   // expected response of one tick; updates the latched start points
   function automatic motion_type trajectory_predict(tick_type t);
      motion_type m;
      longint s;
      longint c;
      longint p;
      longint g;
      longint d;
      longint tz;
      longint zsum;
      longint num;
      int l;
      l = int'(t.leg);
      p = longint'(t.phase);
      if (t.restart) begin
         for (int i = 0; i < NumLegs; i++) relatch[i] = 1'b1;
      end
      m.leg = t.leg;
      for (int a = 0; a < 3; a++) begin
         m.pos[a] = '0;
         m.vel[a] = '0;
      end
      if (relatch[l]) begin
         for (int a = 0; a < 3; a++) start_pt[l][a] = longint'(t.meas[a]);
         relatch[l] = 1'b0;
      end
      if (t.contact) begin
         for (int a = 0; a < 3; a++) begin
            if (t.phase < 16'd32768) start_pt[l][a] = longint'(t.meas[a]);
            m.pos[a] = clip_pos(start_pt[l][a]);
         end
         return m;
      end
      s = sine_of(t.phase);
      c = sine_of(t.phase + 16'd16384);
      // cycloid in x and y
      g = p * 4096 - round_shift(s * 85445659, 16);
      for (int a = 0; a < 2; a++) begin
         d = longint'(t.target[a]) - start_pt[l][a];
         m.pos[a] = clip_pos(start_pt[l][a] + round_shift(d * g, 28));
         m.vel[a] = clip_vel(round_shift(round_shift(d * (32768 - c), 7) * inv_swing, 16));
      end
      // lift profile plus quadratic target term in z
      tz = longint'(t.target[2]);
      zsum = lift_height * (32768 - c) * 16384 + ((p * p) >>> 2) * tz;
      num = lift_height * s * 25736 + p * tz * 8192;
      m.pos[2] = clip_pos(start_pt[l][2] + round_shift(zsum, 30));
      m.vel[2] = clip_vel(round_shift(round_shift(num, 20) * inv_swing, 16));
      return m;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // one request; valid stays high when no gap follows
   task automatic send_tick(tick_type t);
      int gap;
      req_ch.valid    <= 1'b1;
      req_ch.leg      <= t.leg;
      req_ch.contact  <= t.contact;
      req_ch.phase    <= t.phase;
      req_ch.meas_x   <= t.meas[0];
      req_ch.meas_y   <= t.meas[1];
      req_ch.meas_z   <= t.meas[2];
      req_ch.target_x <= t.target[0];
      req_ch.target_y <= t.target[1];
      req_ch.target_z <= t.target[2];
      req_ch.restart  <= t.restart;
      do @(posedge clock); while (!req_ch.ready);
      pending_motion.push_back(trajectory_predict(t));
      request_count++;
      if (!t.contact) swing_count++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_motion.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, then read back
   task automatic write_reg(logic [2:0] addr, logic [31:0] data, logic [31:0] mask);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if ((prdata & mask) != (data & mask)) report_mismatch("register readback", prdata, data & mask);
      psel <= 1'b0;
      penable <= 1'b0;
      if (addr == AddrSwingHeight) lift_height = longint'(data & 32'h3FFFF);
      else inv_swing = longint'(data & 32'hFFFF);
      @(posedge clock);
   endtask

   function automatic cst_pkg::pos_type rand_pos();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 24'sh7FFFFF;
      if (r == 1) return 24'sh800000;
      if (r < 5) return cst_pkg::pos_type'($urandom);
      return cst_pkg::pos_type'($signed($urandom_range(600000)) - 300000);
   endfunction

   function automatic tick_type rand_tick();
      tick_type t;
      t.leg = 2'($urandom);
      t.contact = 1'($urandom);
      t.phase = 16'($urandom);
      for (int a = 0; a < 3; a++) begin
         t.meas[a] = rand_pos();
         t.target[a] = rand_pos();
      end
      t.restart = ($urandom_range(19) == 0);
      return t;
   endfunction

   // response side: random stalls, long ones now and then
   int stall_left;
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_ch.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < 25) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      motion_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         response_count++;
         if (pending_motion.size() == 0) begin
            error_count++;
            $display("MISMATCH at %0t: response with none expected", $realtime);
         end else begin
            want = pending_motion.pop_front();
            if (rsp_ch.out_leg != want.leg) report_mismatch("out_leg", rsp_ch.out_leg, want.leg);
            if (rsp_ch.pos_x != want.pos[0]) report_mismatch("pos_x", rsp_ch.pos_x, want.pos[0]);
            if (rsp_ch.pos_y != want.pos[1]) report_mismatch("pos_y", rsp_ch.pos_y, want.pos[1]);
            if (rsp_ch.pos_z != want.pos[2]) report_mismatch("pos_z", rsp_ch.pos_z, want.pos[2]);
            if (rsp_ch.vel_x != want.vel[0]) report_mismatch("vel_x", rsp_ch.vel_x, want.vel[0]);
            if (rsp_ch.vel_y != want.vel[1]) report_mismatch("vel_y", rsp_ch.vel_y, want.vel[1]);
            if (rsp_ch.vel_z != want.vel[2]) report_mismatch("vel_z", rsp_ch.vel_z, want.vel[2]);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Watchdog expired with %0d responses outstanding", pending_motion.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // first ticks latch the start; field extremes; key phases
   task automatic test_directed();
      tick_type t;
      logic [15:0] phases[7];
      phases = '{16'd0, 16'd16383, 16'd16384, 16'd32767, 16'd32768, 16'd49152, 16'd65535};
      for (int l = 0; l < NumLegs; l++) begin
         t = rand_tick();
         t.leg = 2'(l);
         t.contact = l[0];
         t.phase = 16'd40000;
         t.restart = 1'b0;
         send_tick(t);
      end
      for (int i = 0; i < 7; i++) begin
         t.leg = 2'(i);
         t.contact = 1'b0;
         t.phase = phases[i];
         t.restart = 1'b0;
         for (int a = 0; a < 3; a++) begin
            t.meas[a] = i[0] ? 24'sh7FFFFF : 24'sh800000;
            t.target[a] = i[0] ? 24'sh800000 : 24'sh7FFFFF;
         end
         send_tick(t);
      end
      // stance above and below one half, then restart
      t.contact = 1'b1;
      t.phase = 16'd32767;
      send_tick(t);
      t.phase = 16'd32768;
      t.meas[0] = 24'sd12345;
      send_tick(t);
      t.restart = 1'b1;
      t.contact = 1'b0;
      t.phase = 16'd100;
      send_tick(t);
      t.restart = 1'b0;
      t.leg = 2'd3;
      send_tick(t);
      drain();
   endtask

   // config extremes, each followed by random ticks
   task automatic test_registers();
      logic [31:0] heights[3];
      logic [31:0] rates[4];
      heights = '{32'd0, 32'd262143, 32'd80000};
      rates = '{32'd1, 32'd65535, 32'd0, 32'd1280};
      for (int i = 0; i < 4; i++) begin
         write_reg(AddrSwingHeight, heights[i % 3], 32'h3FFFF);
         write_reg(AddrInvSwingTime, rates[i], 32'hFFFF);
         repeat (6) send_tick(rand_tick());
         drain();
      end
   endtask

   // gait cycles: stance then swing with advancing phase, plus noise
   task automatic test_gait(int n_items);
      tick_type t;
      int sent;
      int steps;
      int stride;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) < 2) begin
            send_tick(rand_tick());
            sent++;
            continue;
         end
         t = rand_tick();
         t.restart = ($urandom_range(29) == 0);
         t.contact = 1'b1;
         steps = $urandom_range(8, 3);
         stride = $urandom_range(12000, 2000);
         t.phase = 16'($urandom_range(30000));
         for (int k = 0; k < steps; k++) begin
            send_tick(t);
            t.restart = 1'b0;
            t.phase = t.phase + 16'(stride / 2);
            for (int a = 0; a < 3; a++) begin
               t.meas[a] = t.meas[a] + cst_pkg::pos_type'($urandom_range(200));
            end
         end
         t.contact = 1'b0;
         t.phase = 16'($urandom_range(2000));
         steps = $urandom_range(10, 4);
         for (int k = 0; k < steps; k++) begin
            send_tick(t);
            t.phase = t.phase + 16'($urandom_range(16000, 4000));
         end
         sent += steps + 8;
      end
   endtask

   task automatic test_random();
      test_gait(200);
      drain();
      write_reg(AddrSwingHeight, $urandom_range(262143), 32'h3FFFF);
      write_reg(AddrInvSwingTime, $urandom_range(65535, 1), 32'hFFFF);
      no_idle = 1'b1;
      test_gait(80);
      no_idle = 1'b0;
      test_gait(200);
      drain();
   endtask

   initial begin
      int wait_cycles;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.leg = '0;
      req_ch.contact = 1'b0;
      req_ch.phase = '0;
      req_ch.meas_x = '0;
      req_ch.meas_y = '0;
      req_ch.meas_z = '0;
      req_ch.target_x = '0;
      req_ch.target_y = '0;
      req_ch.target_z = '0;
      req_ch.restart = 1'b0;
      rsp_ch.ready = 1'b1;
      error_count = 0;
      request_count = 0;
      response_count = 0;
      swing_count = 0;
      idle_cycles = 0;
      no_idle = 1'b0;
      build_sine_table();
      for (int l = 0; l < NumLegs; l++) begin
         relatch[l] = 1'b1;
         for (int a = 0; a < 3; a++) start_pt[l][a] = 0;
      end
      lift_height = 80000;
      inv_swing = 1280;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_registers();
      test_random();

      req_ch.valid <= 1'b0;
      wait_cycles = 0;
      while (pending_motion.size() != 0 && wait_cycles < IdleLimit) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DrainWait) @(posedge clock);
      $display("Covered %0d requests (%0d swing) and %0d responses over register extremes,",
               request_count, swing_count, response_count);
      $display("restarts, stance latching and random gait cycles with stalls on both sides.");
      if (error_count == 0 && pending_motion.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d responses missing", error_count, pending_motion.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/cst_pkg.sv
rtl/core/cst_channels.sv
rtl/core/cst_sine_rom.sv
rtl/core/cst_mul.sv
rtl/core/cst_seq.sv
rtl/core/cycloid_swing_trajectory_core.sv
tb/cycloid_swing_trajectory_core_tb.sv
